// ----- hw/rtl/wmvb_pkg.sv -----
// Package for the weighted moving variance background subtractor.
// Holds register indexes, luma weights and the width helpers shared by
// the top level and the channel pipeline. No dependencies.
package wmvb_pkg;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_COLOR_MODE   = 3'd0,
      CSR_WIDE_SAMPLES = 3'd1,
      CSR_ENABLE_THR   = 3'd2,
      CSR_WEIGHT_CUR   = 3'd3,
      CSR_WEIGHT_PREV  = 3'd4,
      CSR_WEIGHT_OLD   = 3'd5,
      CSR_THRESHOLD    = 3'd6
   } csr_index_type;

   localparam logic [7:0] LUMA_R = 8'd77;
   localparam logic [7:0] LUMA_G = 8'd150;
   localparam logic [7:0] LUMA_B = 8'd29;

   // cycles from the channel input registers to the channel outputs, less the root steps
   localparam int CHAN_FIXED_LAT = 5;

   // widths derived from the weight fraction bits
   function automatic int mean_w(input int f);
      return 39 - f;
   endfunction

   function automatic int dev_w(input int f);
      return ((mean_w(f) > 20) ? mean_w(f) : 20) + 1;
   endfunction

   function automatic int acc_w(input int f);
      return 2 * dev_w(f) + 18;
   endfunction

   function automatic int var_w(input int f);
      return acc_w(f) + 1 - (f + 8);
   endfunction

   function automatic int root_w(input int f);
      return (var_w(f) + 1) / 2;
   endfunction

endpackage

// ----- hw/rtl/wmvb_chan.sv -----
// One channel of the variance pipeline: weighted mean, weighted variance
// and a digit-by-digit square root, one stage per root bit.
// Depends on wmvb_pkg.
module wmvb_chan import wmvb_pkg::*; #(
   parameter int WEIGHT_FRAC_BITS = 16
) (
   input  logic                                      clock,
   input  logic                                      en,
   input  logic [15:0]                               x_cur,
   input  logic [15:0]                               x_prev,
   input  logic [15:0]                               x_old,
   input  logic [15:0]                               w_cur,
   input  logic [15:0]                               w_prev,
   input  logic [15:0]                               w_old,
   output logic [var_w(WEIGHT_FRAC_BITS)-1:0]        var_out,
   output logic [root_w(WEIGHT_FRAC_BITS)-1:0]       root_out
);

   localparam int F      = WEIGHT_FRAC_BITS;
   localparam int SUM_W  = 36;
   localparam int MEAN_W = mean_w(F);
   localparam int DEV_W  = dev_w(F);
   localparam int SQ_W   = 2 * DEV_W;
   localparam int ACC_W  = acc_w(F);
   localparam int VAR_W  = var_w(F);
   localparam int ROOT_W = root_w(F);
   localparam int RAD_W  = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 3;

   // stage 1: weighted samples
   logic [31:0] p0_ff, p1_ff, p2_ff;
   logic [15:0] a1_ff, b1_ff, c1_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff <= w_cur * x_cur;
         p1_ff <= w_prev * x_prev;
         p2_ff <= w_old * x_old;
         a1_ff <= x_cur;
         b1_ff <= x_prev;
         c1_ff <= x_old;
      end
   end

   // stage 2: rounded mean in Q.4
   logic [SUM_W-1:0]  sum_in;
   logic [MEAN_W-1:0] mean_ff;
   logic [15:0]       a2_ff, b2_ff, c2_ff;
   assign sum_in = SUM_W'(p0_ff) + SUM_W'(p1_ff) + SUM_W'(p2_ff)
                 + (SUM_W'(1) << (F - 5));
   always_ff @(posedge clock) begin
      if (en) begin
         mean_ff <= MEAN_W'(sum_in >> (F - 4));
         a2_ff   <= a1_ff;
         b2_ff   <= b1_ff;
         c2_ff   <= c1_ff;
      end
   end

   // stage 3: squared deviations, product taken at full width
   logic signed [DEV_W-1:0] d0, d1, d2;
   logic [SQ_W-1:0]         s0_ff, s1_ff, s2_ff;
   assign d0 = signed'(DEV_W'({a2_ff, 4'b0000})) - signed'(DEV_W'(mean_ff));
   assign d1 = signed'(DEV_W'({b2_ff, 4'b0000})) - signed'(DEV_W'(mean_ff));
   assign d2 = signed'(DEV_W'({c2_ff, 4'b0000})) - signed'(DEV_W'(mean_ff));
   always_ff @(posedge clock) begin
      if (en) begin
         s0_ff <= unsigned'(SQ_W'(d0) * SQ_W'(d0));
         s1_ff <= unsigned'(SQ_W'(d1) * SQ_W'(d1));
         s2_ff <= unsigned'(SQ_W'(d2) * SQ_W'(d2));
      end
   end

   // stage 4: weighted squares
   logic [SQ_W+15:0] q0_ff, q1_ff, q2_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         q0_ff <= s0_ff * w_cur;
         q1_ff <= s1_ff * w_prev;
         q2_ff <= s2_ff * w_old;
      end
   end

   // stage 5: accumulate and round to an integer variance
   logic [ACC_W-1:0] acc_in;
   logic [VAR_W-1:0] var_ff;
   assign acc_in = ACC_W'(q0_ff) + ACC_W'(q1_ff) + ACC_W'(q2_ff)
                 + (ACC_W'(1) << (F + 7));
   always_ff @(posedge clock) begin
      if (en) begin
         var_ff <= VAR_W'(acc_in >> (F + 8));
      end
   end

   // square root, two radicand bits per stage
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];
   logic [VAR_W-1:0]  vcp_ff  [ROOT_W];

   for (genvar i = 0; i < ROOT_W; i++) begin : g_root
      logic [REM_W-1:0]  rem_src;
      logic [ROOT_W-1:0] root_src;
      logic [RAD_W-1:0]  rad_src;
      logic [VAR_W-1:0]  vcp_src;
      logic [REM_W-1:0]  cat;
      logic [REM_W-1:0]  trial;
      logic              ge;
      // first stage starts from the variance, the rest from the stage before
      if (i == 0) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = RAD_W'(var_ff);
         assign vcp_src  = var_ff;
      end else begin : g_next
         assign rem_src  = rem_ff[i-1];
         assign root_src = root_ff[i-1];
         assign rad_src  = rad_ff[i-1];
         assign vcp_src  = vcp_ff[i-1];
      end
      assign cat   = {rem_src[REM_W-3:0], rad_src[RAD_W-1:RAD_W-2]};
      assign trial = REM_W'({root_src, 2'b01});
      assign ge    = (cat >= trial);
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= ge ? (cat - trial) : cat;
            root_ff[i] <= {root_src[ROOT_W-2:0], ge};
            rad_ff[i]  <= rad_src << 2;
            vcp_ff[i]  <= vcp_src;
         end
      end
   end

   assign var_out  = vcp_ff[ROOT_W-1];
   assign root_out = root_ff[ROOT_W-1];

endmodule

// ----- hw/rtl/weighted_moving_variance_bgs.sv -----
// Top level of the weighted moving variance background subtractor:
// frame store, warm-up control, three channel pipelines and output mixing.
// Depends on wmvb_pkg and wmvb_chan.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_tvalid/tready  | tdata: chan_a, chan_b, chan_c; tlast: frame_end
//   rsp     | out       | rsp_tvalid/tready  | tdata: mask_value; tlast: frame_last
//   csr     | in        | csr_we             | csr_addr index, csr_wdata value
//
// One pixel per cycle while rsp is not stalled; the result passes the
// frame store read stage, the channel pipeline with its one-stage-per-bit
// square root, and the output register.
// Reset clears the warm-up count, pixel address, registers and valid bits;
// the frame store is not cleared. A stall of rsp holds the whole pipeline
// and req_tready drops; nothing is lost or repeated.
module weighted_moving_variance_bgs import wmvb_pkg::*; #(
   parameter int MAX_PIXELS       = 65536,
   parameter int WEIGHT_FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // chan_a [15:0], chan_b [31:16], chan_c [47:32]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // mask_value [7:0]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   localparam int F      = WEIGHT_FRAC_BITS;
   localparam int AW     = $clog2(MAX_PIXELS);
   localparam int VAR_W  = var_w(F);
   localparam int ROOT_W = root_w(F);
   localparam int LAT    = CHAN_FIXED_LAT + ROOT_W;
   localparam logic [15:0] WMASK = (F >= 16) ? 16'hFFFF : 16'((1 << F) - 1);

   // configuration registers
   logic        color_ff, wide_ff, thr_en_ff;
   logic [15:0] wcur_ff, wprev_ff, wold_ff;
   logic [31:0] thr_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff  <= 1'b0;
         wide_ff   <= 1'b0;
         thr_en_ff <= 1'b0;
         wcur_ff   <= 16'd32768;
         wprev_ff  <= 16'd19661;
         wold_ff   <= 16'd13107;
         thr_ff    <= 32'd225;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_COLOR_MODE:   color_ff  <= csr_wdata[0];
            CSR_WIDE_SAMPLES: wide_ff   <= csr_wdata[0];
            CSR_ENABLE_THR:   thr_en_ff <= csr_wdata[0];
            CSR_WEIGHT_CUR:   wcur_ff   <= csr_wdata[15:0];
            CSR_WEIGHT_PREV:  wprev_ff  <= csr_wdata[15:0];
            CSR_WEIGHT_OLD:   wold_ff   <= csr_wdata[15:0];
            CSR_THRESHOLD:    thr_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [15:0] wc, wp, wo;
   assign wc = wcur_ff & WMASK;
   assign wp = wprev_ff & WMASK;
   assign wo = wold_ff & WMASK;

   // global advance: pipeline moves unless a result waits untaken
   logic en, accept;
   logic rsp_valid_ff;
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;
   assign accept     = req_tvalid && en;

   // sample masking
   logic [15:0] smask;
   logic [47:0] cur_in;
   assign smask  = wide_ff ? 16'hFFFF : 16'h00FF;
   assign cur_in = {color_ff ? (req_tdata[47:32] & smask) : 16'h0,
                    color_ff ? (req_tdata[31:16] & smask) : 16'h0,
                    req_tdata[15:0] & smask};

   // pixel address and warm-up count
   logic [AW-1:0] addr_ff;
   logic [1:0]    warm_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
         warm_ff <= '0;
      end else if (accept) begin
         if (req_tlast) begin
            addr_ff <= '0;
            if (warm_ff != 2'd2) warm_ff <= warm_ff + 2'd1;
         end else if (addr_ff == AW'(MAX_PIXELS - 1)) begin
            addr_ff <= '0;
         end else begin
            addr_ff <= addr_ff + AW'(1);
         end
      end
   end

   // stage 1: frame store read, with bypass of the write in flight
   logic [95:0]   store [MAX_PIXELS];
   logic [95:0]   rd_ff, byp_ff;
   logic          hit_ff;
   logic          s1_valid_ff, s1_last_ff, s1_emit_ff;
   logic [AW-1:0] s1_addr_ff;
   logic [47:0]   s1_cur_ff, s1_prev, s1_old;
   logic [95:0]   wr_data;

   assign s1_prev = hit_ff ? byp_ff[47:0]  : rd_ff[47:0];
   assign s1_old  = hit_ff ? byp_ff[95:48] : rd_ff[95:48];
   assign wr_data = {s1_prev, s1_cur_ff};

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff      <= store[addr_ff];
         hit_ff     <= s1_valid_ff && (s1_addr_ff == addr_ff);
         byp_ff     <= wr_data;
         s1_addr_ff <= addr_ff;
         s1_cur_ff  <= cur_in;
         s1_last_ff <= req_tlast;
         s1_emit_ff <= (warm_ff == 2'd2);
      end
      if (en && s1_valid_ff) begin
         store[s1_addr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= accept;
      end
   end

   // channel pipelines
   logic [VAR_W-1:0]  var_a, var_b, var_c;
   logic [ROOT_W-1:0] root_a, root_b, root_c;

   wmvb_chan #(.WEIGHT_FRAC_BITS(F)) u_chan_a (
      .clock(clock), .en(en),
      .x_cur(s1_cur_ff[15:0]), .x_prev(s1_prev[15:0]), .x_old(s1_old[15:0]),
      .w_cur(wc), .w_prev(wp), .w_old(wo), .var_out(var_a), .root_out(root_a));
   wmvb_chan #(.WEIGHT_FRAC_BITS(F)) u_chan_b (
      .clock(clock), .en(en),
      .x_cur(s1_cur_ff[31:16]), .x_prev(s1_prev[31:16]), .x_old(s1_old[31:16]),
      .w_cur(wc), .w_prev(wp), .w_old(wo), .var_out(var_b), .root_out(root_b));
   wmvb_chan #(.WEIGHT_FRAC_BITS(F)) u_chan_c (
      .clock(clock), .en(en),
      .x_cur(s1_cur_ff[47:32]), .x_prev(s1_prev[47:32]), .x_old(s1_old[47:32]),
      .w_cur(wc), .w_prev(wp), .w_old(wo), .var_out(var_c), .root_out(root_c));

   // sideband line alongside the channels: valid, last, emit
   logic [LAT-1:0] sb_valid_ff;
   logic [LAT-1:0] sb_last_ff, sb_emit_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         sb_valid_ff <= '0;
      end else if (en) begin
         sb_valid_ff <= {sb_valid_ff[LAT-2:0], s1_valid_ff};
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         sb_last_ff <= {sb_last_ff[LAT-2:0], s1_last_ff};
         sb_emit_ff <= {sb_emit_ff[LAT-2:0], s1_emit_ff};
      end
   end

   // output mixing
   logic [VAR_W+9:0]  yv;
   logic [ROOT_W+9:0] yr, yr_sh;
   logic [7:0]        val_in;
   assign yv    = (VAR_W+10)'(var_a) * LUMA_R + (VAR_W+10)'(var_b) * LUMA_G
                + (VAR_W+10)'(var_c) * LUMA_B;
   assign yr    = (ROOT_W+10)'(root_a) * LUMA_R + (ROOT_W+10)'(root_b) * LUMA_G
                + (ROOT_W+10)'(root_c) * LUMA_B;
   assign yr_sh = yr >> 8;

   always_comb begin
      if (!color_ff) begin
         if (thr_en_ff) val_in = ((VAR_W+32)'(var_a) > (VAR_W+32)'(thr_ff)) ? 8'hFF : 8'h00;
         else           val_in = ((ROOT_W+8)'(root_a) > (ROOT_W+8)'(255)) ? 8'hFF
                                                                          : root_a[7:0];
      end else begin
         if (thr_en_ff) val_in = ((VAR_W+42)'(yv) > ((VAR_W+42)'(thr_ff) << 8)) ? 8'hFF
                                                                               : 8'h00;
         else           val_in = (yr_sh > (ROOT_W+10)'(255)) ? 8'hFF : yr_sh[7:0];
      end
   end

   // output register
   logic [7:0] rsp_data_ff;
   logic       rsp_last_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= sb_valid_ff[LAT-1] && sb_emit_ff[LAT-1];
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= val_in;
         rsp_last_ff <= sb_last_ff[LAT-1];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- hw/rtl/wmvb_checker.sv -----
// Port-level checks for the background subtractor, bound to the top level.
// Depends on weighted_moving_variance_bgs.
module wmvb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // an untaken item holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp item changed while stalled");

   // a stalled result blocks intake
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("req accepted while rsp stalled");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

endmodule

bind weighted_moving_variance_bgs wmvb_checker u_wmvb_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready), .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast));

// ----- bench/wmvb_mask_checker.sv -----
`timescale 1ns / 1ps
// Watches the pixel, mask and register ports of weighted_moving_variance_bgs,
// predicts every mask item from its own frame store and compares in order.
// Depends on wmvb_pkg for the register indexes.
module wmvb_mask_checker import wmvb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata,
   output int          mismatch_count,
   output int          pending_masks
);

   typedef struct packed {
      logic [7:0] mask_value;
      logic       frame_last;
   } mask_item_type;

   // shadow registers
   logic        color_mode, wide_samples, enable_threshold;
   logic [15:0] weight_cur, weight_prev, weight_old;
   logic [31:0] threshold_sq;

   // shadow frame store, entries absent until written read as zero
   logic [47:0]   previous_pix [int];
   logic [47:0]   oldest_pix [int];
   int            pixel_addr;
   int            frames_seen;
   mask_item_type expected_masks [$];

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // weighted variance of one channel, Q.4 mean, rounded to an integer
   function automatic longint unsigned chan_variance(longint unsigned x0, x1, x2);
      longint unsigned w0, w1, w2, s, acc;
      longint          m, d0, d1, d2;
      w0 = weight_cur;
      w1 = weight_prev;
      w2 = weight_old;
      s = w0 * x0 + w1 * x1 + w2 * x2;
      m = longint'((s + 64'd2048) >> 12);
      d0 = longint'(x0 << 4) - m;
      d1 = longint'(x1 << 4) - m;
      d2 = longint'(x2 << 4) - m;
      acc = longint'(d0 * d0) * w0 + longint'(d1 * d1) * w1 + longint'(d2 * d2) * w2;
      return (acc + (64'd1 << 23)) >> 24;
   endfunction

   function automatic logic [7:0] predict_mask(logic [47:0] cur, prev, old);
      longint unsigned v [3];
      longint unsigned y;
      for (int k = 0; k < 3; k++)
         v[k] = chan_variance(cur[16*k +: 16], prev[16*k +: 16], old[16*k +: 16]);
      if (!color_mode) begin
         if (enable_threshold) return (v[0] > threshold_sq) ? 8'hFF : 8'h00;
         y = int_sqrt(v[0]);
      end else if (enable_threshold) begin
         y = LUMA_R * v[0] + LUMA_G * v[1] + LUMA_B * v[2];
         return (y > (longint'(threshold_sq) << 8)) ? 8'hFF : 8'h00;
      end else begin
         y = (LUMA_R * int_sqrt(v[0]) + LUMA_G * int_sqrt(v[1])
              + LUMA_B * int_sqrt(v[2])) >> 8;
      end
      return (y > 255) ? 8'hFF : y[7:0];
   endfunction

   always @(posedge clock) begin
      logic [47:0]   cur, prev, old;
      logic [15:0]   smask;
      mask_item_type got, want;
      if (reset) begin
         color_mode <= 1'b0;
         wide_samples <= 1'b0;
         enable_threshold <= 1'b0;
         weight_cur <= 16'd32768;
         weight_prev <= 16'd19661;
         weight_old <= 16'd13107;
         threshold_sq <= 32'd225;
         pixel_addr <= 0;
         frames_seen <= 0;
         expected_masks.delete();
         mismatch_count <= 0;
         pending_masks <= 0;
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_index_type'(csr_addr))
               CSR_COLOR_MODE:   color_mode <= csr_wdata[0];
               CSR_WIDE_SAMPLES: wide_samples <= csr_wdata[0];
               CSR_ENABLE_THR:   enable_threshold <= csr_wdata[0];
               CSR_WEIGHT_CUR:   weight_cur <= csr_wdata[15:0];
               CSR_WEIGHT_PREV:  weight_prev <= csr_wdata[15:0];
               CSR_WEIGHT_OLD:   weight_old <= csr_wdata[15:0];
               CSR_THRESHOLD:    threshold_sq <= csr_wdata;
               default: ;
            endcase
         end
         // compare mask items in order
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata, rsp_tlast};
            if (expected_masks.size() == 0) begin
               $display("%0t: unexpected mask item, actual %h/%b", $time, rsp_tdata, rsp_tlast);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_masks.pop_front();
               if (got !== want) begin
                  $display("%0t: mask mismatch, expected %h/%b actual %h/%b", $time,
                           want.mask_value, want.frame_last, got.mask_value, got.frame_last);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         // predict each accepted pixel item
         if (req_tvalid && req_tready) begin
            smask = wide_samples ? 16'hFFFF : 16'h00FF;
            cur = {req_tdata[47:32] & smask, req_tdata[31:16] & smask,
                   req_tdata[15:0] & smask};
            if (!color_mode) cur[47:16] = '0;
            prev = previous_pix.exists(pixel_addr) ? previous_pix[pixel_addr] : '0;
            old = oldest_pix.exists(pixel_addr) ? oldest_pix[pixel_addr] : '0;
            if (frames_seen >= 2) expected_masks.push_back('{predict_mask(cur, prev, old),
                                                           req_tlast});
            oldest_pix[pixel_addr] = prev;
            previous_pix[pixel_addr] = cur;
            if (req_tlast) begin
               pixel_addr <= 0;
               if (frames_seen < 2) frames_seen <= frames_seen + 1;
            end else begin
               pixel_addr <= (pixel_addr + 1) % 65536;
            end
         end
         pending_masks <= expected_masks.size();
      end
   end

endmodule

// ----- bench/tb_weighted_moving_variance_bgs.sv -----
`timescale 1ns / 1ps
// Top of the bench for weighted_moving_variance_bgs: drives pixel frames and
// register phases with random idling. Depends on wmvb_pkg and wmvb_mask_checker.
module tb_weighted_moving_variance_bgs;
   import wmvb_pkg::*;

   localparam int FRAME_MAX  = 64;
   localparam int PIXEL_GOAL = 1400;
   localparam int DRAIN_WAIT = 40;
   localparam int STALL_LIMIT = 3000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [31:0] csr_wdata = '0;
   int          mismatch_count, pending_masks;
   int          pixels_sent;
   int          idle_cycles;
   int          rsp_hold;
   logic        send_busy, take_busy;
   logic [15:0] base_level;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   weighted_moving_variance_bgs DUT (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast,
      .csr_we, .csr_addr, .csr_wdata
   );

   wmvb_mask_checker checker_i (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast,
      .csr_we, .csr_addr, .csr_wdata, .mismatch_count, .pending_masks
   );

   // mask side stalls, drawn per item
   initial take_busy = 1'b0;
   initial rsp_hold = 0;
   always @(posedge clock) begin
      int hold;
      hold = rsp_hold;
      if (rsp_tvalid && rsp_tready) hold = take_busy ? 0 : $urandom_range(0, 11);
      if (hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold <= hold - 1;
      end else begin
         rsp_tready <= 1'b1;
         rsp_hold <= 0;
      end
   end

   // watchdog on cycles without any accepted item
   initial idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_pixel(input logic [15:0] a, b, c, input logic last);
      int gap;
      gap = send_busy ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {c, b, a};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
   endtask

   // wait until all masks are back, then let the pipeline empty
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_masks != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
   endtask

   task automatic configure(input logic color, wide, thr, input logic [15:0] wc, wp, wo,
                            input logic [31:0] thr_sq);
      write_reg(CSR_COLOR_MODE, {31'd0, color});
      write_reg(CSR_WIDE_SAMPLES, {31'd0, wide});
      write_reg(CSR_ENABLE_THR, {31'd0, thr});
      write_reg(CSR_WEIGHT_CUR, {16'd0, wc});
      write_reg(CSR_WEIGHT_PREV, {16'd0, wp});
      write_reg(CSR_WEIGHT_OLD, {16'd0, wo});
      write_reg(CSR_THRESHOLD, thr_sq);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // sample near a background level, with full-range and extreme outliers
   function automatic logic [15:0] draw_sample();
      case ($urandom_range(0, 5))
         0: return 16'($urandom);
         1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: return base_level + 16'($urandom_range(0, 48));
      endcase
   endfunction

   task automatic send_frame(input int len);
      send_busy = ($urandom_range(0, 3) == 0);
      take_busy = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++)
         send_pixel(draw_sample(), draw_sample(), draw_sample(), i == len - 1);
   endtask

   initial begin
      logic [15:0] corner [8];
      corner = '{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00, 16'h5555, 16'hAAAA,
                 16'h0001, 16'h8000};
      pixels_sent = 0;
      send_busy = 1'b0;
      base_level = 16'h0040;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      configure(1'b0, 1'b0, 1'b0, 16'd32768, 16'd19661, 16'd13107, 32'd225);

      // warm-up: two full-length frames fill every store entry in use
      send_frame(FRAME_MAX);
      send_frame(FRAME_MAX);

      // directed frame: extreme samples against each other
      send_busy = 1'b0;
      for (int i = 0; i < 16; i++)
         send_pixel(corner[i % 8], corner[(i + 3) % 8], corner[(i + 5) % 8], i == 15);
      drain();

      // register phases, extremes first, then random settings
      for (int phase = 0; pixels_sent < PIXEL_GOAL; phase++) begin
         case (phase)
            0: configure(1'b1, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd0);
            1: configure(1'b0, 1'b1, 1'b1, 16'd0, 16'd0, 16'd0, 32'hFFFFFFFF);
            2: configure(1'b1, 1'b1, 1'b0, 16'hFFFF, 16'd0, 16'd0, 32'd0);
            3: configure(1'b1, 1'b0, 1'b0, 16'd0, 16'hFFFF, 16'hFFFF, 32'd225);
            4: configure(1'b0, 1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd1);
            default: configure(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                               16'($urandom),
                               $urandom_range(0, 3) == 0 ? $urandom
                                                         : $urandom_range(0, 4000));
         endcase
         base_level = 16'($urandom);
         for (int f = 0; f < 4; f++)
            send_frame($urandom_range(0, 7) == 0 ? FRAME_MAX : $urandom_range(1, FRAME_MAX));
         drain();
      end

      drain();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0 && pending_masks == 0) begin
         $display("CHECK OK");
      end else begin
         if (pending_masks != 0)
            $display("%0t: %0d expected mask items never arrived", $time, pending_masks);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
